>>> hw/rtl/tdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

    localparam int BYTE_W     = 8;
    localparam int APP_ID_W   = 16;
    localparam int PAYLOAD_W  = 32;
    localparam int ERR_CNT_W  = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [BYTE_W-1:0] ESC_XOR        = 8'h20;
    localparam logic [BYTE_W-1:0] CHECK_GOOD     = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ESC_BYTE   = 8'h7D;
    localparam logic [BYTE_W-1:0] RST_MARKER     = 8'h10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE   = 2'd0,
        REG_ESCAPE_BYTE  = 2'd1,
        REG_FRAME_MARKER = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SENSOR = 4'd1,
        PH_MARKER = 4'd2,
        PH_APP1   = 4'd3,
        PH_APP2   = 4'd4,
        PH_DAT1   = 4'd5,
        PH_DAT2   = 4'd6,
        PH_DAT3   = 4'd7,
        PH_DAT4   = 4'd8,
        PH_CHECK  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] frame_marker;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    node_id;
        logic [APP_ID_W-1:0]  app_id;
        logic [PAYLOAD_W-1:0] payload;
        logic                 check_ok;
        logic [ERR_CNT_W-1:0] error_count;
    } frame_t;

    // 8-bit add with end-around carry
    function automatic logic [BYTE_W-1:0] sum_fold(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tdf_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tdf_byte_if;
    import tdf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tdf_frame_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tdf_frame_if;
    import tdf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    node_id;
    logic [APP_ID_W-1:0]  app_id;
    logic [PAYLOAD_W-1:0] payload;
    logic                 check_ok;
    logic [ERR_CNT_W-1:0] error_count;

    modport source (
        output valid, output node_id, output app_id, output payload,
        output check_ok, output error_count, input ready
    );
    modport sink (
        input valid, input node_id, input app_id, input payload,
        input check_ok, input error_count, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/tdf_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tdf_cfg_if;
    import tdf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tdf_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tdf_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tdf_cfg_if.sink      cfg,
    output tdf_pkg::cfg_t regs
);
    import tdf_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_BYTE:   regs_next.start_byte   = cfg.data;
                REG_ESCAPE_BYTE:  regs_next.escape_byte  = cfg.data;
                REG_FRAME_MARKER: regs_next.frame_marker = cfg.data;
                default:          regs_next = regs_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_byte   <= RST_START_BYTE;
            regs_reg.escape_byte  <= RST_ESC_BYTE;
            regs_reg.frame_marker <= RST_MARKER;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tdf_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tdf_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tdf_byte_if.sink      rx,
    input  tdf_pkg::cfg_t cfg,
    output logic          res_valid,
    output tdf_pkg::frame_t res,
    input  wire logic     res_ready
);
    import tdf_pkg::*;

    // input word register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    phase_t               phase_reg, phase_next;
    logic                 pending_reg, pending_next;
    logic [BYTE_W-1:0]    id_reg, id_next;
    logic [APP_ID_W-1:0]  appid_reg, appid_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [BYTE_W-1:0]    acc_reg, acc_next;
    logic [ERR_CNT_W-1:0] fail_reg, fail_next;

    logic              emit;
    logic              fire;
    logic              is_start;
    logic              in_body;
    logic              is_esc;
    logic              check_ok;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] acc_sum;

    assign is_start = (in_byte_reg == cfg.start_byte);
    assign b        = pending_reg ? (in_byte_reg ^ ESC_XOR) : in_byte_reg;
    assign in_body  = phase_reg inside {[PH_APP1:PH_CHECK]};
    assign is_esc   = (b == cfg.escape_byte) && in_body;
    assign acc_sum  = sum_fold(acc_reg, b);
    assign check_ok = (acc_sum == CHECK_GOOD);

    // only the checksum word needs room downstream
    assign fire     = in_valid_reg && (!emit || res_ready);
    assign rx.ready = !in_valid_reg || fire;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        id_next      = id_reg;
        appid_next   = appid_reg;
        payload_next = payload_reg;
        acc_next     = acc_reg;
        fail_next    = fail_reg;
        emit         = 1'b0;

        if (is_start)
        begin
            // restart; a pending escape survives
            phase_next = PH_SENSOR;
        end
        else if (is_esc)
        begin
            pending_next = 1'b1;
        end
        else
        begin
            pending_next = 1'b0;
            case (phase_reg)
                PH_SENSOR:
                begin
                    id_next    = b;
                    phase_next = PH_MARKER;
                end
                PH_MARKER:
                begin
                    if (b == cfg.frame_marker)
                    begin
                        acc_next   = b;
                        phase_next = PH_APP1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_APP1:
                begin
                    appid_next[7:0] = b;
                    acc_next        = acc_sum;
                    phase_next      = PH_APP2;
                end
                PH_APP2:
                begin
                    appid_next[15:8] = b;
                    acc_next         = acc_sum;
                    phase_next       = PH_DAT1;
                end
                PH_DAT1:
                begin
                    payload_next[7:0] = b;
                    acc_next          = acc_sum;
                    phase_next        = PH_DAT2;
                end
                PH_DAT2:
                begin
                    payload_next[15:8] = b;
                    acc_next           = acc_sum;
                    phase_next         = PH_DAT3;
                end
                PH_DAT3:
                begin
                    payload_next[23:16] = b;
                    acc_next            = acc_sum;
                    phase_next          = PH_DAT4;
                end
                PH_DAT4:
                begin
                    payload_next[31:24] = b;
                    acc_next            = acc_sum;
                    phase_next          = PH_CHECK;
                end
                PH_CHECK:
                begin
                    acc_next   = acc_sum;
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                    if (!check_ok)
                    begin
                        fail_next = fail_reg + {{(ERR_CNT_W-1){1'b0}}, 1'b1};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid       = in_valid_reg && emit;
        res.node_id     = id_reg;
        res.app_id      = appid_reg;
        res.payload     = payload_reg;
        res.check_ok    = check_ok;
        res.error_count = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            pending_reg  <= 1'b0;
            id_reg       <= '0;
            appid_reg    <= '0;
            payload_reg  <= '0;
            acc_reg      <= '0;
            fail_reg     <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (fire)
            begin
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                id_reg      <= id_next;
                appid_reg   <= appid_next;
                payload_reg <= payload_next;
                acc_reg     <= acc_next;
                fail_reg    <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tdf_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module tdf_out_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_valid,
    input  tdf_pkg::frame_t res,
    output logic            res_ready,
    tdf_frame_if.source     tx
);
    import tdf_pkg::*;

    logic   out_valid_reg;
    frame_t out_reg;

    // take a new word when empty or when the held one leaves
    assign res_ready = !out_valid_reg || tx.ready;

    assign tx.valid       = out_valid_reg;
    assign tx.node_id     = out_reg.node_id;
    assign tx.app_id      = out_reg.app_id;
    assign tx.payload     = out_reg.payload;
    assign tx.check_ok    = out_reg.check_ok;
    assign tx.error_count = out_reg.error_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/telemetry_frame_deframer_top.sv
// Path: a checksum byte taken on rx is held in the input register and feeds the parser;
// the frame word it completes is captured in the result register, which drives tx.
// Throughput: one byte per cycle; the only stall is a full result register holding
// a frame word while the next checksum byte waits.
// Reset: rst_n clears parser state, error count and valid flags at once and loads
// the default start, escape and marker bytes.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_deframer_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdf_cfg_if.sink     cfg,
    tdf_byte_if.sink    rx,
    tdf_frame_if.source tx
);
    import tdf_pkg::*;

    cfg_t   cfg_regs;
    frame_t res;
    logic   res_valid;
    logic   res_ready;

    tdf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    tdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg_regs),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    tdf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .tx        (tx)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tdf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tdf_cfg_if   cfg_bus ();
    tdf_byte_if  rx_bus ();
    tdf_frame_if tx_bus ();

    telemetry_frame_deframer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .rx    (rx_bus),
        .tx    (tx_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Raw bytes waiting to go out, and the frames the parser must produce
    logic [BYTE_W-1:0] bytes_pending [$];
    frame_t            frames_due [$];
    logic [BYTE_W-1:0] frame_raw [$];

    // Parser model state
    cfg_t                 cur_cfg = '{RST_START_BYTE, RST_ESC_BYTE, RST_MARKER};
    phase_t               pr_phase = PH_IDLE;
    logic                 pr_pend = 1'b0;
    logic [BYTE_W-1:0]    pr_id = '0;
    logic [APP_ID_W-1:0]  pr_app = '0;
    logic [PAYLOAD_W-1:0] pr_pay = '0;
    logic [BYTE_W-1:0]    pr_sum = '0;
    logic [ERR_CNT_W-1:0] pr_fails = '0;

    int     src_idle_pct = 25;
    int     sink_idle_pct = 49;
    logic   sink_hold = 1'b0;
    int     mismatches = 0;
    int     bytes_sent = 0;
    int     cycles = 0;
    frame_t got_frame;
    frame_t want_frame;

    // 8-bit add with end-around carry
    function automatic logic [BYTE_W-1:0] add_wrap(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s > 255)
            s = s - 255;
        return s[BYTE_W-1:0];
    endfunction

    task automatic deframe_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        logic              ok;
        b = raw;
        // start byte is matched on the raw value; a pending escape survives it
        if (b == cur_cfg.start_byte)
        begin
            pr_phase = PH_SENSOR;
            return;
        end
        if (pr_pend)
        begin
            b = b ^ ESC_XOR;
            pr_pend = 1'b0;
        end
        if (b == cur_cfg.escape_byte && pr_phase > PH_MARKER && pr_phase <= PH_CHECK)
            pr_pend = 1'b1;
        else if (pr_phase == PH_SENSOR)
        begin
            pr_id = b;
            pr_phase = PH_MARKER;
        end
        else if (pr_phase == PH_MARKER && b == cur_cfg.frame_marker)
        begin
            pr_sum = b;
            pr_phase = PH_APP1;
        end
        else if (pr_phase == PH_APP1)
        begin
            pr_app[7:0] = b;
            pr_phase = PH_APP2;
        end
        else if (pr_phase == PH_APP2)
        begin
            pr_app[15:8] = b;
            pr_phase = PH_DAT1;
        end
        else if (pr_phase >= PH_DAT1 && pr_phase <= PH_DAT4)
        begin
            pr_pay[8 * (int'(pr_phase) - int'(PH_DAT1)) +: 8] = b;
            pr_phase = phase_t'(pr_phase + 4'd1);
        end
        else if (pr_phase == PH_CHECK)
        begin
            pr_sum = add_wrap(pr_sum, b);
            ok = (pr_sum == 8'hFF);
            if (!ok)
                pr_fails = pr_fails + 1;
            frames_due.push_back('{node_id: pr_id, app_id: pr_app, payload: pr_pay,
                                   check_ok: ok, error_count: pr_fails});
            pr_pend = 1'b0;
            pr_phase = PH_IDLE;
        end
        else
        begin
            pr_pend = 1'b0;
            pr_phase = PH_IDLE;
        end
        if (pr_phase > PH_APP1 && pr_phase <= PH_CHECK && !pr_pend)
            pr_sum = add_wrap(pr_sum, b);
    endtask

    // Bias toward the byte values that steer the parser
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(15))
            0: return cur_cfg.start_byte;
            1: return cur_cfg.escape_byte;
            2: return cur_cfg.frame_marker;
            3: return cur_cfg.escape_byte ^ ESC_XOR;
            4: return 8'h00;
            5: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_frame(input logic [BYTE_W-1:0] sid, input logic [APP_ID_W-1:0] app,
                               input logic [PAYLOAD_W-1:0] pay, input bit good);
        logic [BYTE_W-1:0] body [7];
        logic [BYTE_W-1:0] acc;
        frame_raw.delete();
        body[0] = app[7:0];
        body[1] = app[15:8];
        for (int i = 0; i < 4; i++)
            body[2 + i] = pay[8 * i +: 8];
        acc = cur_cfg.frame_marker;
        for (int i = 0; i < 6; i++)
            acc = add_wrap(acc, body[i]);
        body[6] = good ? 8'hFF - acc : pick_byte();
        frame_raw.push_back(cur_cfg.start_byte);
        frame_raw.push_back(sid);
        frame_raw.push_back(cur_cfg.frame_marker);
        for (int i = 0; i < 7; i++)
        begin
            // stuff anything that would look like a start or escape byte
            if (body[i] == cur_cfg.start_byte || body[i] == cur_cfg.escape_byte)
            begin
                frame_raw.push_back(cur_cfg.escape_byte);
                frame_raw.push_back(body[i] ^ ESC_XOR);
            end
            else
                frame_raw.push_back(body[i]);
        end
    endtask

    task automatic send_raw(input int n);
        for (int i = 0; i < n; i++)
            bytes_pending.push_back(frame_raw[i]);
        bytes_sent += n;
    endtask

    task automatic wait_drained();
        while (bytes_pending.size() != 0 || rx_bus.valid || frames_due.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_START_BYTE:   cur_cfg.start_byte = val;
            REG_ESCAPE_BYTE:  cur_cfg.escape_byte = val;
            REG_FRAME_MARKER: cur_cfg.frame_marker = val;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_bus.valid   <= 1'b0;
            rx_bus.rx_byte <= '0;
        end
        else
        begin
            if (rx_bus.valid && rx_bus.ready)
                deframe_byte(rx_bus.rx_byte);
            if (!rx_bus.valid || rx_bus.ready)
            begin
                if (bytes_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= bytes_pending.pop_front();
                end
                else
                    rx_bus.valid <= 1'b0;
            end
        end
    end

    // Frame monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_bus.ready <= 1'b0;
        else
        begin
            if (tx_bus.valid && tx_bus.ready)
            begin
                got_frame = '{tx_bus.node_id, tx_bus.app_id, tx_bus.payload,
                              tx_bus.check_ok, tx_bus.error_count};
                if (frames_due.size() == 0)
                begin
                    $error("frame word with none pending: %p", got_frame);
                    mismatches++;
                end
                else
                begin
                    want_frame = frames_due.pop_front();
                    check_field("node_id", 32'(want_frame.node_id), 32'(got_frame.node_id));
                    check_field("app_id", 32'(want_frame.app_id), 32'(got_frame.app_id));
                    check_field("payload", want_frame.payload, got_frame.payload);
                    check_field("check_ok", 32'(want_frame.check_ok),
                                32'(got_frame.check_ok));
                    check_field("error_count", want_frame.error_count,
                                got_frame.error_count);
                end
            end
            tx_bus.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        cfg_t              nxt;
        logic [BYTE_W-1:0] sid;
        int                target;
        int                n;

        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = '0;
        cfg_bus.data   = '0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        tx_bus.ready   = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                case (p)
                    2: nxt = '{8'h00, 8'hFF, 8'hFF};
                    3: nxt = '{8'hFF, 8'h00, 8'h00};
                    5: nxt = '{RST_START_BYTE, RST_ESC_BYTE, RST_MARKER};
                    default:
                    begin
                        nxt.start_byte = 8'($urandom_range(255));
                        do
                            nxt.escape_byte = 8'($urandom_range(255));
                        while (nxt.escape_byte == nxt.start_byte);
                        do
                            nxt.frame_marker = 8'($urandom_range(255));
                        while (nxt.frame_marker == nxt.start_byte);
                    end
                endcase
                write_reg(REG_START_BYTE, nxt.start_byte);
                write_reg(REG_ESCAPE_BYTE, nxt.escape_byte);
                write_reg(REG_FRAME_MARKER, nxt.frame_marker);
                if (p == 2)
                    write_reg(REG_UNUSED, 8'($urandom_range(255)));
                @(negedge clk);
            end

            src_idle_pct  <= (p < 2) ? 25 : (p < 4) ? 49 : 0;
            sink_idle_pct <= (p < 2) ? 49 : (p < 4) ? 25 : 0;

            if (p == 0)
            begin
                // idle noise, escape byte outside the stuffed region
                bytes_pending.push_back(8'h00);
                bytes_pending.push_back(RST_ESC_BYTE);
                bytes_pending.push_back(8'hFF);
                // good frame with stuffed app id bytes
                build_frame(8'h00, {RST_ESC_BYTE, RST_START_BYTE}, 32'hFFFF_0000, 1'b1);
                send_raw(frame_raw.size());
                // wrong marker drops back to idle
                bytes_pending.push_back(RST_START_BYTE);
                bytes_pending.push_back(8'h01);
                bytes_pending.push_back(RST_MARKER ^ 8'h01);
                // escape pending across a restart
                bytes_pending.push_back(RST_START_BYTE);
                bytes_pending.push_back(8'h05);
                bytes_pending.push_back(RST_MARKER);
                bytes_pending.push_back(RST_ESC_BYTE);
                build_frame(8'hFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
                send_raw(frame_raw.size());
            end

            if (p == 1)
            begin
                fork
                    begin
                        @(posedge clk);
                        sink_hold <= 1'b1;
                        repeat (400) @(posedge clk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end

            target = bytes_sent + 200;
            while (bytes_sent < target)
            begin
                while (bytes_pending.size() > 32)
                    @(negedge clk);
                sid = pick_byte();
                if (sid == cur_cfg.start_byte)
                    sid = sid ^ 8'h01;
                n = $urandom_range(99);
                if (n < 82)
                begin
                    build_frame(sid, {pick_byte(), pick_byte()},
                                {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                                n < 70);
                    send_raw(frame_raw.size());
                end
                else if (n < 90)
                begin
                    // truncated frame
                    build_frame(sid, 16'($urandom), $urandom, 1'b1);
                    send_raw($urandom_range(1, frame_raw.size() - 1));
                end
                else if (n < 95)
                begin
                    // one byte replaced anywhere after the start byte
                    build_frame(sid, 16'($urandom), $urandom, 1'b1);
                    frame_raw[$urandom_range(1, frame_raw.size() - 1)] = pick_byte();
                    send_raw(frame_raw.size());
                end
                else
                begin
                    frame_raw.delete();
                    repeat ($urandom_range(1, 4))
                        frame_raw.push_back(pick_byte());
                    send_raw(frame_raw.size());
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (frames_due.size() != 0)
        begin
            $error("%0d frames never arrived", frames_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
